// File: hw/rtl/colray_pkg.sv
// Shared types, constants and the sine ROM builder for the column ray caster.
// Depends on nothing; the front end, queue, marcher and top level import it.

package colray_pkg;

   // Fixed geometry of the cast.
   localparam int MAP_SIZE   = 16;
   localparam int MAX_STEPS  = 31;
   localparam int TRIG_DEPTH = 1024;
   localparam int TRIG_IDX_W = $clog2(TRIG_DEPTH);

   // Field widths.
   localparam int COL_W     = 10;
   localparam int CELL_W    = 4;
   localparam int ANGLE_W   = 16;
   localparam int FOV_W     = 15;
   localparam int COLS_W    = 10;
   localparam int ROWS_W    = 8;
   localparam int DIST_W    = 5;
   localparam int CEIL_W    = 8;
   localparam int FLOOR_W   = 9;
   localparam int SHADE_W   = 3;
   localparam int UNIT_W    = 16;
   localparam int FRAC_W    = 14;
   localparam int SPAN_W    = FOV_W + COLS_W;

   // Register file.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PLAYER_X    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAYER_Y    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_ANGLE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_COLS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_ROWS = 3'd5;

   localparam logic [CELL_W-1:0]  RESET_PLAYER_X    = 4'd2;
   localparam logic [CELL_W-1:0]  RESET_PLAYER_Y    = 4'd2;
   localparam logic [ANGLE_W-1:0] RESET_VIEW_ANGLE  = 16'd16384;
   localparam logic [FOV_W-1:0]   RESET_VIEW_WIDTH  = 15'd8192;
   localparam logic [COLS_W-1:0]  RESET_SCREEN_COLS = 10'd80;
   localparam logic [ROWS_W-1:0]  RESET_SCREEN_ROWS = 8'd24;

   // Shade codes by distance band.
   localparam logic [SHADE_W-1:0] SHADE_NEAR  = 3'd0;
   localparam logic [SHADE_W-1:0] SHADE_CLOSE = 3'd1;
   localparam logic [SHADE_W-1:0] SHADE_MID   = 3'd2;
   localparam logic [SHADE_W-1:0] SHADE_FAR   = 3'd3;
   localparam logic [SHADE_W-1:0] SHADE_FAINT = 3'd4;

   // pi/2 in Q30.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [CELL_W-1:0]  cell_x;
      logic [CELL_W-1:0]  cell_y;
      logic [ANGLE_W-1:0] view_angle;
      logic [FOV_W-1:0]   view_width;
      logic [COLS_W-1:0]  screen_cols;
      logic [ROWS_W-1:0]  screen_rows;
   } colray_cfg_type;

   // One ray handed from the front end to the marcher.
   typedef struct packed {
      logic [COL_W-1:0]      column;
      logic [TRIG_IDX_W-1:0] idx;
   } colray_ray_type;

   typedef logic signed [UNIT_W-1:0] trig_rom_type [TRIG_DEPTH];

   function automatic logic signed [UNIT_W-1:0] to_q14(input logic signed [63:0] sum);
      logic signed [63:0] clamped;
      logic signed [63:0] rounded;
      clamped = (sum < 0) ? 64'sd0 : sum;
      rounded = (clamped + 64'sd32768) >>> 16;
      return rounded[UNIT_W-1:0];
   endfunction

   // Taylor series in Q30, each term derived from the previous one.
   function automatic logic signed [UNIT_W-1:0] sin_first(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      return to_q14(sum);
   endfunction

   function automatic logic signed [UNIT_W-1:0] cos_first(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = signed'(term);
      term = ((term * x2) >> 30) / 64'd2;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd12;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd30;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd56;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd90;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd132;
      sum  = sum + signed'(term);
      return to_q14(sum);
   endfunction

   // Full-turn sine table in Q2.14; cosine is the entry a quarter turn ahead.
   function automatic trig_rom_type build_trig_rom();
      trig_rom_type rom;
      logic [31:0] m;
      logic [31:0] rem;
      logic [1:0]  quad;
      logic [63:0] x;
      for (int k = 0; k < TRIG_DEPTH; k++) begin
         m    = 32'(4 * k);
         quad = 2'(m / TRIG_DEPTH);
         rem  = m % TRIG_DEPTH;
         x    = (HALF_PI_Q30 * 64'(rem)) / TRIG_DEPTH;
         case (quad)
            2'd0:    rom[k] = sin_first(x);
            2'd1:    rom[k] = cos_first(x);
            2'd2:    rom[k] = -sin_first(x);
            default: rom[k] = -cos_first(x);
         endcase
      end
      return rom;
   endfunction

endpackage

// File: hw/rtl/column_raycaster.sv
// Top level of the column ray caster: register file, front end, ray queue and marcher.
// Depends on colray_pkg, colray_front, colray_fifo and colray_back.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_column
//   rsp      out        rsp_valid / rsp_ready  rsp_column_out, rsp_wall_distance,
//                                              rsp_ceiling_row, rsp_floor_row, rsp_shade
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// The front end works out each column's angle with its 25-bit radix-2 divider; the marcher
// steps the ray once per march step and then divides; neither takes a new column before it
// is through with the last one, and the slower of the two sets the sustained rate.
// A result beat waits in an output register while the next ray is already marched.
// Reset is synchronous and loads the register defaults; csr_ready is always high.

module column_raycaster #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [colray_pkg::COL_W-1:0]        req_column,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [colray_pkg::COL_W-1:0]        rsp_column_out,
   output logic [colray_pkg::DIST_W-1:0]       rsp_wall_distance,
   output logic signed [colray_pkg::CEIL_W-1:0] rsp_ceiling_row,
   output logic [colray_pkg::FLOOR_W-1:0]      rsp_floor_row,
   output logic [colray_pkg::SHADE_W-1:0]      rsp_shade,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [colray_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [colray_pkg::CSR_DATA_W-1:0]   csr_data
);

   import colray_pkg::*;

   colray_cfg_type cfg_ff, cfg_in;
   logic           push_valid;
   logic           push_ready;
   colray_ray_type push_data;
   logic           pop_valid;
   logic           pop_ready;
   colray_ray_type pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PLAYER_X:    cfg_in.cell_x      = csr_data[CELL_W-1:0];
            CSR_PLAYER_Y:    cfg_in.cell_y      = csr_data[CELL_W-1:0];
            CSR_VIEW_ANGLE:  cfg_in.view_angle  = csr_data[ANGLE_W-1:0];
            CSR_VIEW_WIDTH:  cfg_in.view_width  = csr_data[FOV_W-1:0];
            CSR_SCREEN_COLS: cfg_in.screen_cols = csr_data[COLS_W-1:0];
            CSR_SCREEN_ROWS: cfg_in.screen_rows = csr_data[ROWS_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_x      <= RESET_PLAYER_X;
         cfg_ff.cell_y      <= RESET_PLAYER_Y;
         cfg_ff.view_angle  <= RESET_VIEW_ANGLE;
         cfg_ff.view_width  <= RESET_VIEW_WIDTH;
         cfg_ff.screen_cols <= RESET_SCREEN_COLS;
         cfg_ff.screen_rows <= RESET_SCREEN_ROWS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   colray_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_column (req_column),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   colray_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   colray_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_column_out    (rsp_column_out),
      .rsp_wall_distance (rsp_wall_distance),
      .rsp_ceiling_row   (rsp_ceiling_row),
      .rsp_floor_row     (rsp_floor_row),
      .rsp_shade         (rsp_shade)
   );

endmodule

// File: hw/rtl/colray_div.sv
// Restoring divider, one quotient bit per cycle, used by both halves of the caster.
// Depends on nothing outside this file.

module colray_div #(
   parameter int DIVIDEND_W = 8,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   // The dividend shifts out of the top of quo_ff while quotient bits enter at the bottom.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/colray_fifo.sv
// Small ray queue between the angle front end and the marcher.
// Depends on colray_pkg for the ray type.

module colray_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  colray_pkg::colray_ray_type push_data,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output colray_pkg::colray_ray_type pop_data
);

   import colray_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   colray_ray_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/colray_front.sv
// Front end: takes a column beat, works out the ray angle and its table index.
// Depends on colray_pkg and colray_div.

module colray_front (
   input  logic                       clock,
   input  logic                       reset,
   input  colray_pkg::colray_cfg_type cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [colray_pkg::COL_W-1:0] req_column,
   output logic                       push_valid,
   input  logic                       push_ready,
   output colray_pkg::colray_ray_type push_data
);

   import colray_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIVIDE,
      ST_PUSH
   } state_type;

   state_type          state_ff, state_in;
   logic [COL_W-1:0]   column_ff, column_in;
   logic [SPAN_W-1:0]  product_ff, product_in;
   logic [ANGLE_W-1:0] span_ff, span_in;
   logic               div_start;
   logic               div_done;
   logic [SPAN_W-1:0]  div_quotient;
   logic [ANGLE_W-1:0] angle;

   colray_div #(
      .DIVIDEND_W (SPAN_W),
      .DIVISOR_W  (COLS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_ff),
      .divisor  (cfg.screen_cols),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in   = state_ff;
      column_in  = column_ff;
      product_in = product_ff;
      span_in    = span_ff;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               column_in  = req_column;
               product_in = {{COLS_W{1'b0}}, cfg.view_width} * {{FOV_W{1'b0}}, req_column};
               state_in   = ST_START;
            end
         end
         ST_START: begin
            // With no columns configured the column term drops out.
            if (cfg.screen_cols == '0) begin
               span_in  = '0;
               state_in = ST_PUSH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               span_in  = div_quotient[ANGLE_W-1:0];
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      column_ff  <= column_in;
      product_ff <= product_in;
      span_ff    <= span_in;
   end

   // The angle wraps at a full turn; the table index is its top bits.
   assign angle = cfg.view_angle - {2'b00, cfg.view_width[FOV_W-1:1]} + span_ff;

   assign req_ready        = (state_ff == ST_IDLE);
   assign push_valid       = (state_ff == ST_PUSH);
   assign push_data.column = column_ff;
   assign push_data.idx    = angle[ANGLE_W-1 -: TRIG_IDX_W];

endmodule

// File: hw/rtl/colray_back.sv
// Back end: looks up the ray direction, marches it through the map and forms the result beat.
// Depends on colray_pkg and colray_div.

module colray_back (
   input  logic                          clock,
   input  logic                          reset,
   input  colray_pkg::colray_cfg_type    cfg,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  colray_pkg::colray_ray_type    pop_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [colray_pkg::COL_W-1:0]  rsp_column_out,
   output logic [colray_pkg::DIST_W-1:0] rsp_wall_distance,
   output logic signed [colray_pkg::CEIL_W-1:0] rsp_ceiling_row,
   output logic [colray_pkg::FLOOR_W-1:0] rsp_floor_row,
   output logic [colray_pkg::SHADE_W-1:0] rsp_shade
);

   import colray_pkg::*;

   localparam int PROD_W = UNIT_W + DIST_W + 1;
   localparam int POS_W  = 8;
   localparam int CALC_W = ROWS_W + 2;

   localparam trig_rom_type TRIG_ROM = build_trig_rom();

   localparam logic signed [POS_W-1:0] POS_LAST = POS_W'(MAP_SIZE - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARCH,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [COL_W-1:0]          column_ff, column_in;
   logic [DIST_W-1:0]         dist_ff, dist_in;
   logic signed [UNIT_W-1:0]  sin_ff;
   logic signed [UNIT_W-1:0]  cos_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]          rsp_column_ff, rsp_column_in;
   logic [DIST_W-1:0]         rsp_dist_ff, rsp_dist_in;
   logic [CEIL_W-1:0]         rsp_ceiling_ff, rsp_ceiling_in;
   logic [FLOOR_W-1:0]        rsp_floor_ff, rsp_floor_in;
   logic [SHADE_W-1:0]        rsp_shade_ff, rsp_shade_in;

   logic                      pop_fire;
   logic [TRIG_IDX_W-1:0]     cos_idx;
   logic signed [PROD_W-1:0]  prod_x;
   logic signed [PROD_W-1:0]  prod_y;
   logic signed [POS_W-1:0]   pos_x;
   logic signed [POS_W-1:0]   pos_y;
   logic                      hit;
   logic                      div_start;
   logic                      div_done;
   logic [ROWS_W-1:0]         div_quotient;
   logic [CALC_W-1:0]         ceil_full;
   logic [CALC_W-1:0]         floor_full;
   logic [SHADE_W-1:0]        shade;

   // Offset at the current distance: the Q2.14 product truncated toward zero.
   function automatic logic signed [POS_W-1:0] trunc_offset(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] whole;
      mag   = p[PROD_W-1] ? $unsigned(-p) : $unsigned(p);
      whole = mag >> FRAC_W;
      return p[PROD_W-1] ? -$signed(whole[POS_W-1:0]) : $signed(whole[POS_W-1:0]);
   endfunction

   colray_div #(
      .DIVIDEND_W (ROWS_W),
      .DIVISOR_W  (DIST_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.screen_rows),
      .divisor  (dist_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign pop_ready = (state_ff == ST_IDLE);
   assign pop_fire  = pop_valid && pop_ready;
   assign cos_idx   = pop_data.idx + TRIG_IDX_W'(TRIG_DEPTH / 4);

   // Direction lookup: both components are registered together when a ray is popped.
   always_ff @(posedge clock) begin
      if (pop_fire) begin
         sin_ff <= TRIG_ROM[pop_data.idx];
         cos_ff <= TRIG_ROM[cos_idx];
      end
   end

   // Anything on or outside the border is wall.
   always_comb begin
      prod_x = PROD_W'(cos_ff) * PROD_W'($signed({1'b0, dist_ff}));
      prod_y = PROD_W'(sin_ff) * PROD_W'($signed({1'b0, dist_ff}));
      pos_x  = $signed({{(POS_W - CELL_W){1'b0}}, cfg.cell_x}) + trunc_offset(prod_x);
      pos_y  = $signed({{(POS_W - CELL_W){1'b0}}, cfg.cell_y}) + trunc_offset(prod_y);
      hit    = (pos_x <= 0) || (pos_x >= POS_LAST) || (pos_y <= 0) || (pos_y >= POS_LAST);
   end

   always_comb begin
      ceil_full  = CALC_W'(cfg.screen_rows[ROWS_W-1:1]) - CALC_W'(div_quotient);
      floor_full = CALC_W'(cfg.screen_rows) - ceil_full;
      if (dist_ff < DIST_W'(4)) begin
         shade = SHADE_NEAR;
      end else if (dist_ff < DIST_W'(8)) begin
         shade = SHADE_CLOSE;
      end else if (dist_ff < DIST_W'(12)) begin
         shade = SHADE_MID;
      end else if (dist_ff < DIST_W'(16)) begin
         shade = SHADE_FAR;
      end else begin
         shade = SHADE_FAINT;
      end
   end

   always_comb begin
      state_in       = state_ff;
      column_in      = column_ff;
      dist_in        = dist_ff;
      div_start      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_column_in  = rsp_column_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_ceiling_in = rsp_ceiling_ff;
      rsp_floor_in   = rsp_floor_ff;
      rsp_shade_in   = rsp_shade_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               column_in = pop_data.column;
               dist_in   = DIST_W'(1);
               state_in  = ST_MARCH;
            end
         end
         ST_MARCH: begin
            // The last step is not tested: the distance saturates there.
            if (hit || dist_ff == DIST_W'(MAX_STEPS)) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               dist_in = dist_ff + 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_column_in  = column_ff;
               rsp_dist_in    = dist_ff;
               rsp_ceiling_in = ceil_full[CEIL_W-1:0];
               rsp_floor_in   = floor_full[FLOOR_W-1:0];
               rsp_shade_in   = shade;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      column_ff      <= column_in;
      dist_ff        <= dist_in;
      rsp_column_ff  <= rsp_column_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_ceiling_ff <= rsp_ceiling_in;
      rsp_floor_ff   <= rsp_floor_in;
      rsp_shade_ff   <= rsp_shade_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column_out    = rsp_column_ff;
   assign rsp_wall_distance = rsp_dist_ff;
   assign rsp_ceiling_row   = $signed(rsp_ceiling_ff);
   assign rsp_floor_row     = rsp_floor_ff;
   assign rsp_shade         = rsp_shade_ff;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for column_raycaster: predicts every ray cast from its own trig table
// and march, and checks each result beat in order. Depends on colray_pkg and the RTL top level.

module testbench;
   import colray_pkg::*;

   localparam int CLOCK_HALF    = 2;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 64;
   localparam int HANG_LIMIT    = 4000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_COLUMNS = 50;
   localparam int QUARTER_TURN  = TRIG_DEPTH / 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      logic [COL_W-1:0]          column;
      logic [DIST_W-1:0]         distance;
      logic signed [CEIL_W-1:0]  ceiling;
      logic [FLOOR_W-1:0]        floor_row;
      logic [SHADE_W-1:0]        shade;
   } ray_cast_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [COL_W-1:0]          req_column;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [COL_W-1:0]          rsp_column_out;
   logic [DIST_W-1:0]         rsp_wall_distance;
   logic signed [CEIL_W-1:0]  rsp_ceiling_row;
   logic [FLOOR_W-1:0]        rsp_floor_row;
   logic [SHADE_W-1:0]        rsp_shade;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;

   logic signed [UNIT_W-1:0]  unit_sine [TRIG_DEPTH];
   colray_cfg_type            reg_mirror;
   ray_cast_type              pending_casts [$];
   ray_cast_type              oldest;
   int                        mismatches = 0;
   int                        hang_cycles = 0;
   int                        burst_left = 0;
   bit                        idle_bursts = 1'b1;
   int                        stall_left = 0;
   int                        stall_style = 0;

   column_raycaster dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_column        (req_column),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_column_out    (rsp_column_out),
      .rsp_wall_distance (rsp_wall_distance),
      .rsp_ceiling_row   (rsp_ceiling_row),
      .rsp_floor_row     (rsp_floor_row),
      .rsp_shade         (rsp_shade),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Taylor sum in Q30 of sine or cosine of the first-quadrant angle x, rounded to Q14.
   function automatic logic signed [UNIT_W-1:0] taylor_q14(input longint unsigned x,
                                                         input bit cosine);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned divisor;
      longint          acc;
      int              n;
      x2   = (x * x) >> 30;
      term = cosine ? (64'd1 << 30) : x;
      acc  = term;
      for (n = 1; n <= (cosine ? 6 : 5); n++) begin
         divisor = cosine ? longint'((2 * n - 1) * (2 * n)) : longint'((2 * n) * (2 * n + 1));
         term    = ((term * x2) >> 30) / divisor;
         acc     = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0)
         acc = 0;
      return UNIT_W'((acc + 32768) >>> 16);
   endfunction

   function automatic ray_cast_type cast_column_ray(input logic [COL_W-1:0] column);
      ray_cast_type cast;
      logic [31:0]  span;
      logic [31:0]  angle;
      int           idx;
      int           ux;
      int           uy;
      int           steps;
      int           cx;
      int           cy;
      int           rows;
      int           ceil_r;
      span = 0;
      if (reg_mirror.screen_cols != 0)
         span = (32'(reg_mirror.view_width) * 32'(column)) / 32'(reg_mirror.screen_cols);
      angle = (32'(reg_mirror.view_angle) - 32'(reg_mirror.view_width >> 1) + span) & 32'hFFFF;
      idx = int'(angle[ANGLE_W-1:ANGLE_W-TRIG_IDX_W]);
      ux  = unit_sine[(idx + QUARTER_TURN) % TRIG_DEPTH];
      uy  = unit_sine[idx];
      // Offsets truncate toward zero; a cell on or past the border is a wall.
      for (steps = 1; steps < MAX_STEPS; steps++) begin
         cx = int'(reg_mirror.cell_x) + (ux * steps) / (1 << FRAC_W);
         cy = int'(reg_mirror.cell_y) + (uy * steps) / (1 << FRAC_W);
         if (cx <= 0 || cy <= 0 || cx >= MAP_SIZE - 1 || cy >= MAP_SIZE - 1)
            break;
      end
      rows   = int'(reg_mirror.screen_rows);
      ceil_r = rows / 2 - rows / steps;
      cast.column    = column;
      cast.distance  = DIST_W'(steps);
      cast.ceiling   = CEIL_W'(ceil_r);
      cast.floor_row = FLOOR_W'(rows - ceil_r);
      if (steps < 4)
         cast.shade = SHADE_NEAR;
      else if (steps < 8)
         cast.shade = SHADE_CLOSE;
      else if (steps < 12)
         cast.shade = SHADE_MID;
      else if (steps < 16)
         cast.shade = SHADE_FAR;
      else
         cast.shade = SHADE_FAINT;
      return cast;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] expected,
                                       input logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", field, $signed(expected), $signed(actual));
         mismatches++;
      end
   endfunction

   // Receiver: switches now and then between always ready, coin flips and long stalls.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else begin
         case (stall_style)
            0: rsp_ready = 1'b1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            default: begin
               rsp_ready = 1'b1;
               if ($urandom_range(0, 15) == 0)
                  stall_left = $urandom_range(1, 20);
            end
         endcase
      end
      if ($urandom_range(0, 299) == 0)
         stall_style = $urandom_range(0, 2);
   end

   // Predict on every accepted column, compare on every accepted result beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            pending_casts.push_back(cast_column_ray(req_column));
         if (rsp_valid && rsp_ready) begin
            if (pending_casts.size() == 0) begin
               $error("result beat for column %0d with no cast outstanding", rsp_column_out);
               mismatches++;
            end else begin
               oldest = pending_casts.pop_front();
               check_field("column_out", oldest.column, rsp_column_out);
               check_field("wall_distance", oldest.distance, rsp_wall_distance);
               check_field("ceiling_row", oldest.ceiling, rsp_ceiling_row);
               check_field("floor_row", oldest.floor_row, rsp_floor_row);
               check_field("shade", oldest.shade, rsp_shade);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         hang_cycles = 0;
      else
         hang_cycles++;
      if (hang_cycles >= HANG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PLAYER_X:    reg_mirror.cell_x      = value[CELL_W-1:0];
         CSR_PLAYER_Y:    reg_mirror.cell_y      = value[CELL_W-1:0];
         CSR_VIEW_ANGLE:  reg_mirror.view_angle  = value[ANGLE_W-1:0];
         CSR_VIEW_WIDTH:  reg_mirror.view_width  = value[FOV_W-1:0];
         CSR_SCREEN_COLS: reg_mirror.screen_cols = value[COLS_W-1:0];
         CSR_SCREEN_ROWS: reg_mirror.screen_rows = value[ROWS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_casts.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_config(input logic [CELL_W-1:0] px, input logic [CELL_W-1:0] py,
                              input logic [ANGLE_W-1:0] angle, input logic [FOV_W-1:0] width,
                              input logic [COLS_W-1:0] cols, input logic [ROWS_W-1:0] rows);
      drain_results();
      write_reg(CSR_PLAYER_X, CSR_DATA_W'(px));
      write_reg(CSR_PLAYER_Y, CSR_DATA_W'(py));
      write_reg(CSR_VIEW_ANGLE, CSR_DATA_W'(angle));
      write_reg(CSR_VIEW_WIDTH, CSR_DATA_W'(width));
      write_reg(CSR_SCREEN_COLS, CSR_DATA_W'(cols));
      write_reg(CSR_SCREEN_ROWS, CSR_DATA_W'(rows));
   endtask

   // Called at a falling edge. Valid is only lowered when a gap follows, so back-to-back
   // beats keep it high.
   task automatic send_column(input logic [COL_W-1:0] column);
      req_valid  = 1'b1;
      req_column = column;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else if (idle_bursts) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   task automatic test_reset_defaults();
      send_column(10'd0);
      send_column(10'd39);
      send_column(10'd79);
   endtask

   task automatic test_register_extremes();
      drain_results();
      // A write to an unmapped index must leave every register alone.
      write_reg(CSR_SPARE, 16'hFFFF);
      send_column(10'd1022);
      load_config(4'd0, 4'd15, 16'hFFFF, 15'h7FFF, 10'd1023, 8'd255);
      send_column(10'd0);
      send_column(10'd511);
      send_column(10'd1022);
      load_config(4'd15, 4'd0, 16'd0, 15'd0, 10'd1, 8'd1);
      send_column(10'd0);
      send_column(10'd1);
      send_column(10'd1022);
   endtask

   task automatic test_special_cases();
      // Zero columns and zero rows at once.
      load_config(4'd7, 4'd7, 16'd8192, 15'd16384, 10'd0, 8'd0);
      send_column(10'd0);
      send_column(10'd700);
      // Columns past the right edge of the screen wrap the angle.
      load_config(4'd7, 4'd8, 16'd40000, 15'd20000, 10'd10, 8'd60);
      send_column(10'd10);
      send_column(10'd1022);
      // Rays that leave the map straight away, eastward and westward.
      load_config(4'd15, 4'd8, 16'd0, 15'd0, 10'd80, 8'd24);
      send_column(10'd0);
      load_config(4'd0, 4'd8, 16'd32768, 15'd0, 10'd80, 8'd24);
      send_column(10'd0);
      // Player in a corner wall cell, then the longest diagonal across the room.
      load_config(4'd0, 4'd0, 16'd8192, 15'd0, 10'd80, 8'd200);
      send_column(10'd0);
      load_config(4'd1, 4'd1, 16'd8192, 15'd0, 10'd80, 8'd200);
      send_column(10'd0);
   endtask

   task automatic test_random_casts();
      logic [COLS_W-1:0] cols;
      int                phase;
      int                n;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         cols = ($urandom_range(0, 1) == 0) ? COLS_W'($urandom_range(1, 1023))
                                            : COLS_W'($urandom_range(1, 96));
         load_config(($urandom_range(0, 3) == 0) ? CELL_W'($urandom)
                                                 : CELL_W'($urandom_range(1, 14)),
                     ($urandom_range(0, 3) == 0) ? CELL_W'($urandom)
                                                 : CELL_W'($urandom_range(1, 14)),
                     ANGLE_W'($urandom),
                     ($urandom_range(0, 3) == 0) ? FOV_W'($urandom)
                                                 : FOV_W'($urandom_range(0, 16384)),
                     cols, ROWS_W'($urandom_range(1, 255)));
         idle_bursts = ($urandom_range(0, 3) != 0);
         for (n = 0; n < PHASE_COLUMNS; n++) begin
            // Once mid-phase, hold off until every outstanding cast has come back.
            if (phase == RANDOM_PHASES / 2 && n == PHASE_COLUMNS / 2)
               drain_results();
            if ($urandom_range(0, 3) == 0)
               send_column(COL_W'($urandom_range(0, 1022)));
            else
               send_column(COL_W'($urandom_range(0, int'(cols) - 1)));
         end
      end
   endtask

   initial begin
      int k;
      int quad;
      int rem;
      longint unsigned x;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_column = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      reg_mirror.cell_x      = RESET_PLAYER_X;
      reg_mirror.cell_y      = RESET_PLAYER_Y;
      reg_mirror.view_angle  = RESET_VIEW_ANGLE;
      reg_mirror.view_width  = RESET_VIEW_WIDTH;
      reg_mirror.screen_cols = RESET_SCREEN_COLS;
      reg_mirror.screen_rows = RESET_SCREEN_ROWS;
      // Full-turn sine table; the quadrant picks sine or cosine of the remainder and its sign.
      for (k = 0; k < TRIG_DEPTH; k++) begin
         quad = (4 * k) / TRIG_DEPTH;
         rem  = (4 * k) % TRIG_DEPTH;
         x    = (HALF_PI_Q30 * 64'(rem)) / TRIG_DEPTH;
         case (quad)
            0:       unit_sine[k] = taylor_q14(x, 1'b0);
            1:       unit_sine[k] = taylor_q14(x, 1'b1);
            2:       unit_sine[k] = -taylor_q14(x, 1'b0);
            default: unit_sine[k] = -taylor_q14(x, 1'b1);
         endcase
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_register_extremes();
      test_special_cases();
      test_random_casts();

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
